// ----- src/hufenc_pkg.sv -----
package hufenc_pkg;

    localparam int BYTE_W        = 8;
    localparam int CODE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int ENTRY_W       = LEN_W + CODE_W;
    localparam int PEND_W        = BYTE_W - 1;
    localparam int PCNT_W        = 3;
    localparam int ACC_W         = PEND_W + CODE_W;
    localparam int NBITS_W       = 4;
    localparam int TOTAL_W       = 32;
    localparam int SYMBOL_W      = 8;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam int DEF_MAX_CODE_LEN = 16;
    localparam int DEF_NUM_SYMBOLS  = 256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]          op;
        logic [SYMBOL_W-1:0] symbol;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_W-1:0]    code_length;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [NBITS_W-1:0] bits_in_byte;
        logic               last;
        logic [TOTAL_W-1:0] total_bits;
    } t_out_word;

    // Push request into the result queue; en1 is only ever set with en0.
    typedef struct packed {
        logic en0;
        logic en1;
    } t_fifo_push;

endpackage

// ----- src/huffman_encoder_bit_packer_core.sv -----
// Huffman encoder bit packer. Each input word is a code table load, a symbol to
// encode or a flush; one word is taken per cycle unless the input stalls. A word
// goes through two stages: the code table (a synchronous memory, one entry per
// symbol) is read when the word is taken, and then the code from the registered
// entry is appended to the pending bits, producing up to two full bytes. Results
// queue in a four-deep buffer that hands out one word per cycle unless stalled,
// so the sustained rate is one input word per cycle while each encode yields at
// most one byte on average, and otherwise the output bytes set the pace; the
// input stalls while a word waits in the second stage and the buffer has fewer
// than two free places. A flush gives one word with the last partial byte
// left-aligned and the total bit count, then clears pending bits and count.
// Table loads take effect for any encode taken in a later cycle.
module huffman_encoder_bit_packer_core
    import hufenc_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = DEF_NUM_SYMBOLS
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_out
);

    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int ADDR_W    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    logic [ENTRY_W-1:0] r_table [NUM_SYMBOLS];
    logic [ENTRY_W-1:0] r_entry;

    logic               r_s1_valid;
    logic [1:0]         r_s1_op;
    logic               r_s1_in_range;

    logic [PEND_W-1:0]  r_pend;
    logic [PCNT_W-1:0]  r_pcnt;
    logic [TOTAL_W-1:0] r_total;
    logic [PEND_W-1:0]  n_pend;
    logic [PCNT_W-1:0]  n_pcnt;
    logic [TOTAL_W-1:0] n_total;

    logic               w_accept;
    logic               w_in_range;
    logic [ADDR_W-1:0]  w_addr;
    logic [LEN_W-1:0]   w_load_len;
    logic [CODE_W:0]    w_load_mask;
    logic [CODE_W-1:0]  w_load_code;

    logic               w_go;
    logic               w_room2;
    logic [LEN_W-1:0]   w_clen;
    logic [CODE_W:0]    w_cmask;
    logic [CODE_W-1:0]  w_cbits;
    logic [ACC_W-1:0]   w_acc;
    logic [LEN_W-1:0]   w_n;
    logic [LEN_W-1:0]   w_sh0;
    logic [LEN_W-1:0]   w_sh1;
    logic [ACC_W-1:0]   w_acc_sh0;
    logic [ACC_W-1:0]   w_acc_sh1;
    logic [PEND_W:0]    w_pmask;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] w_total_enc;
    logic               w_enc;
    logic               w_flush;

    t_fifo_push         w_push;
    t_out_word          w_word0;
    t_out_word          w_word1;

    // Stage 0: accept, table write for loads, table read for every word.
    assign w_go       = w_room2;
    assign o_stall    = r_s1_valid && !w_go;
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = ({1'b0, i_in.symbol} < (SYMBOL_W + 1)'(NUM_SYMBOLS));
    assign w_addr     = ADDR_W'(i_in.symbol);

    always_comb begin
        if (i_in.code_length > LEN_W'(LEN_LIMIT)) begin
            w_load_len = LEN_W'(LEN_LIMIT);
        end else begin
            w_load_len = i_in.code_length;
        end
        w_load_mask = ((CODE_W + 1)'(1) << w_load_len) - (CODE_W + 1)'(1);
        w_load_code = i_in.code_bits & w_load_mask[CODE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entry <= r_table[w_addr];
            if ((i_in.op == OP_LOAD) && w_in_range) begin
                r_table[w_addr] <= {w_load_len, w_load_code};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op       <= i_in.op;
            r_s1_in_range <= w_in_range;
        end
    end

    // Stage 1: append the code, or flush, and cut off whole bytes, oldest bits first.
    always_comb begin
        if (r_entry[ENTRY_W-1:CODE_W] > LEN_W'(LEN_LIMIT)) begin
            w_clen = LEN_W'(LEN_LIMIT);
        end else begin
            w_clen = r_entry[ENTRY_W-1:CODE_W];
        end
        w_cmask   = ((CODE_W + 1)'(1) << w_clen) - (CODE_W + 1)'(1);
        w_cbits   = r_entry[CODE_W-1:0] & w_cmask[CODE_W-1:0];
        w_acc     = (ACC_W'(r_pend) << w_clen) | ACC_W'(w_cbits);
        w_n       = LEN_W'(r_pcnt) + w_clen;
        w_sh0     = w_n - LEN_W'(BYTE_W);
        w_sh1     = w_n - LEN_W'(2 * BYTE_W);
        w_acc_sh0 = w_acc >> w_sh0;
        w_acc_sh1 = w_acc >> w_sh1;
        w_pmask   = ((PEND_W + 1)'(1) << w_n[PCNT_W-1:0]) - (PEND_W + 1)'(1);
        w_sum     = {1'b0, r_total} + (TOTAL_W + 1)'(w_clen);
        if (w_sum[TOTAL_W]) begin
            w_total_enc = '1;
        end else begin
            w_total_enc = w_sum[TOTAL_W-1:0];
        end
    end

    assign w_enc   = r_s1_valid && w_go && (r_s1_op == OP_ENCODE) && r_s1_in_range
                     && (w_clen != '0);
    assign w_flush = r_s1_valid && w_go && (r_s1_op == OP_FLUSH);

    always_comb begin
        n_pend       = r_pend;
        n_pcnt       = r_pcnt;
        n_total      = r_total;
        w_push.en0   = 1'b0;
        w_push.en1   = 1'b0;
        w_word0.out_byte     = w_acc_sh0[BYTE_W-1:0];
        w_word0.bits_in_byte = NBITS_W'(BYTE_W);
        w_word0.last         = 1'b0;
        w_word0.total_bits   = w_total_enc;
        w_word1.out_byte     = w_acc_sh1[BYTE_W-1:0];
        w_word1.bits_in_byte = NBITS_W'(BYTE_W);
        w_word1.last         = 1'b0;
        w_word1.total_bits   = w_total_enc;
        if (w_enc) begin
            n_pend     = w_acc[PEND_W-1:0] & w_pmask[PEND_W-1:0];
            n_pcnt     = w_n[PCNT_W-1:0];
            n_total    = w_total_enc;
            w_push.en0 = (w_n >= LEN_W'(BYTE_W));
            w_push.en1 = (w_n >= LEN_W'(2 * BYTE_W));
        end else if (w_flush) begin
            n_pend     = '0;
            n_pcnt     = '0;
            n_total    = '0;
            w_push.en0 = 1'b1;
            w_word0.out_byte     = BYTE_W'({1'b0, r_pend} << (PCNT_W'(BYTE_W) - r_pcnt));
            w_word0.bits_in_byte = NBITS_W'(r_pcnt);
            w_word0.last         = 1'b1;
            w_word0.total_bits   = r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_pcnt  <= '0;
            r_total <= '0;
        end else begin
            r_pend  <= n_pend;
            r_pcnt  <= n_pcnt;
            r_total <= n_total;
        end
    end

    hufenc_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word0 (w_word0),
        .i_word1 (w_word1),
        .o_room2 (w_room2),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule

// ----- src/hufenc_result_fifo.sv -----
module hufenc_result_fifo
    import hufenc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_push i_push,
    input  t_out_word  i_word0,
    input  t_out_word  i_word1,
    output logic       o_room2,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_word  o_out
);

    t_out_word               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic [FIFO_CNT_W-1:0]   n_count;
    logic [FIFO_PTR_W-1:0]   n_wr_ptr;
    logic [FIFO_PTR_W-1:0]   w_wr_ptr1;
    logic                    w_pop;
    logic [1:0]              w_npush;

    assign w_pop     = o_valid && !i_stall;
    assign w_npush   = {1'b0, i_push.en0} + {1'b0, i_push.en1};
    assign w_wr_ptr1 = r_wr_ptr + FIFO_PTR_W'(1);
    assign n_wr_ptr  = r_wr_ptr + FIFO_PTR_W'(w_npush);
    assign n_count   = r_count + FIFO_CNT_W'(w_npush) - FIFO_CNT_W'(w_pop);

    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_out   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en0) begin
            r_mem[r_wr_ptr] <= i_word0;
        end
        if (i_push.en1) begin
            r_mem[w_wr_ptr1] <= i_word1;
        end
    end

endmodule

// ----- src/hufenc_checker.sv -----
module hufenc_checker
    import hufenc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_out
);

    // The result queue empties on reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("stalled output word changed or vanished");

    // Bytes from encodes are always full.
    a_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.last |-> o_out.bits_in_byte == NBITS_W'(BYTE_W))
        else $error("encode word with a partial byte");

    // A flush word carries at most seven bits, and its unused low bits are zero.
    a_flush_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.last |-> o_out.bits_in_byte < NBITS_W'(BYTE_W))
        else $error("flush word with a full byte count");

    a_flush_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.last |->
            (o_out.out_byte & (8'hFF >> o_out.bits_in_byte)) == '0)
        else $error("flush word with nonzero padding");

endmodule

bind huffman_encoder_bit_packer_core hufenc_checker u_hufenc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
